// File: design/mvt_pkg.sv
package mvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int DATA_W        = 32;
    localparam int ENTRIES       = LANES * LANES;
    localparam int IDX_W         = $clog2(ENTRIES);

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_XFORM = 1'b1
    } t_kind;

    typedef logic signed [DATA_W-1:0] t_q;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] row;
        logic [1:0] col;
        t_q         element;
        t_q         vec_x;
        t_q         vec_y;
        t_q         vec_z;
        t_q         vec_w;
    } t_in_word;

    typedef struct packed {
        t_q   out_x;
        t_q   out_y;
        t_q   out_z;
        t_q   out_w;
        logic overflow;
    } t_out_word;

endpackage

// File: design/mvt_stream_if.sv
interface mvt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/matrix_vector_transform_4x4.sv
// 4x4 matrix-vector transform in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). A load word (kind = 0) writes one matrix element at
// (row, col) and gives no result; a transform word (kind = 1) gives one result
// holding the stored matrix times (x, y, z, w), each row rounded half up and
// clamped to 32 bits, with overflow set when any row was clamped. The matrix is
// all zero after reset, and a load is seen by the very next word. The block
// takes one word per cycle while the skid stage is empty; a result passes through
// four register stages: products, four-way sum, round and clamp, output register.
// A skid stage at the output parks one word when the output stalls, so the input
// keeps flowing until the skid is full.
module matrix_vector_transform_4x4 #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mvt_stream_if.sink   i_in,
    mvt_stream_if.source o_out
);
    localparam int DEPTH = 3;

    mvt_pkg::t_q       r_matrix [mvt_pkg::ENTRIES];
    mvt_pkg::t_q       w_row    [mvt_pkg::LANES][mvt_pkg::LANES];
    mvt_pkg::t_q       w_vec    [mvt_pkg::LANES];
    mvt_pkg::t_q       w_val    [mvt_pkg::LANES];
    logic [mvt_pkg::LANES-1:0] w_sat;
    logic [DEPTH-1:0]  r_vld;
    logic              w_en;
    logic              w_fire;
    logic              w_load;
    logic [mvt_pkg::IDX_W-1:0] w_idx;

    // The whole pipeline advances together; it stops only when the skid is full.
    assign i_in.ready = w_en;
    assign w_fire     = i_in.valid && w_en;
    assign w_load     = w_fire && (i_in.data.kind == mvt_pkg::KIND_LOAD);
    assign w_idx      = {i_in.data.row, i_in.data.col};

    assign w_vec[0] = i_in.data.vec_x;
    assign w_vec[1] = i_in.data.vec_y;
    assign w_vec[2] = i_in.data.vec_z;
    assign w_vec[3] = i_in.data.vec_w;

    // Matrix store: element (row, col) lives at row * 4 + col.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mvt_pkg::ENTRIES; i++) begin
                r_matrix[i] <= '0;
            end
        end else if (w_load) begin
            r_matrix[w_idx] <= i_in.data.element;
        end
    end

    // Track which pipeline slots carry a transform; load words leave a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], w_fire && (i_in.data.kind == mvt_pkg::KIND_XFORM)};
        end
    end

    // One lane per matrix row, each fed its fixed row of the store.
    for (genvar r = 0; r < mvt_pkg::LANES; r++) begin : g_lane
        for (genvar c = 0; c < mvt_pkg::LANES; c++) begin : g_tap
            assign w_row[r][c] = r_matrix[r * mvt_pkg::LANES + c];
        end

        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_row (w_row[r]),
            .i_vec (w_vec),
            .o_val (w_val[r]),
            .o_sat (w_sat[r])
        );
    end

    mvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[DEPTH-1]),
        .i_val   (w_val),
        .i_sat   (w_sat),
        .o_ready (w_en),
        .o_out   (o_out)
    );

    a_load_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_matrix[$past(w_idx)] == $past(i_in.data.element))
        else $error("load word did not reach the matrix store");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !r_vld[0])
        else $error("load word entered the pipeline as a transform");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
endmodule

// File: design/mvt_lane.sv
// One matrix row dotted with the vector: multiply, add, round and clamp.
module mvt_lane #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  mvt_pkg::t_q i_row [mvt_pkg::LANES],
    input  mvt_pkg::t_q i_vec [mvt_pkg::LANES],
    output mvt_pkg::t_q o_val,
    output logic        o_sat
);
    localparam int PROD_W = 2 * mvt_pkg::DATA_W;
    localparam int SUM_W  = PROD_W + $clog2(mvt_pkg::LANES);
    localparam int RND_W  = SUM_W + 1;
    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] MAX_V =
        {{(RND_W - mvt_pkg::DATA_W + 1){1'b0}}, {(mvt_pkg::DATA_W - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] MIN_V =
        {{(RND_W - mvt_pkg::DATA_W + 1){1'b1}}, {(mvt_pkg::DATA_W - 1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod [mvt_pkg::LANES];
    logic signed [PROD_W-1:0] n_prod [mvt_pkg::LANES];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [RND_W-1:0]  w_rnd;
    mvt_pkg::t_q              r_val;
    mvt_pkg::t_q              n_val;
    logic                     r_sat;
    logic                     n_sat;

    always_comb begin
        for (int c = 0; c < mvt_pkg::LANES; c++) begin
            n_prod[c] = PROD_W'(i_row[c]) * PROD_W'(i_vec[c]);
        end
        n_sum = '0;
        for (int c = 0; c < mvt_pkg::LANES; c++) begin
            n_sum = n_sum + SUM_W'(r_prod[c]);
        end
    end

    // Round half up, then clamp to the word range.
    always_comb begin
        w_rnd = (RND_W'(r_sum) + HALF) >>> FRAC_BITS;
        if (w_rnd > MAX_V) begin
            n_val = MAX_V[mvt_pkg::DATA_W-1:0];
            n_sat = 1'b1;
        end else if (w_rnd < MIN_V) begin
            n_val = MIN_V[mvt_pkg::DATA_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_val = w_rnd[mvt_pkg::DATA_W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
            r_val  <= n_val;
            r_sat  <= n_sat;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;
endmodule

// File: design/mvt_merge.sv
// Gather the lane results into one word, with an output register and a skid stage.
module mvt_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  mvt_pkg::t_q            i_val [mvt_pkg::LANES],
    input  logic [mvt_pkg::LANES-1:0] i_sat,
    output logic                   o_ready,
    mvt_stream_if.source           o_out
);
    mvt_pkg::t_out_word w_word;
    mvt_pkg::t_out_word r_out;
    mvt_pkg::t_out_word n_out;
    mvt_pkg::t_out_word r_skid;
    mvt_pkg::t_out_word n_skid;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_skid_valid;
    logic               n_skid_valid;
    logic               w_fire;

    assign w_word = '{out_x: i_val[0], out_y: i_val[1], out_z: i_val[2], out_w: i_val[3],
                      overflow: |i_sat};
    assign w_fire = i_valid && !r_skid_valid;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = w_word;
                n_out_valid  = w_fire;
            end
        end else if (w_fire) begin
            // park the word while the output is stalled
            n_skid       = w_word;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready     = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while the output is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && o_out.ready |=> !r_skid_valid && r_out_valid)
        else $error("skid word not moved to the output");
endmodule
